### hw/rtl/rtfp_pkg.sv
// rtfp_pkg: types and constants for the radar TLV frame parser.
// No dependencies; used by the top level.
`default_nettype none

package rtfp_pkg;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_RHDR   = 2'd2,
		PH_VALUE  = 2'd3
	} phase_t;

	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_SIDE  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SMALL   = 2'd1;
	localparam logic [1:0] ST_HDR_CUT = 2'd2;
	localparam logic [1:0] ST_OVERRUN = 2'd3;

	localparam logic [1:0] CFG_POINT_TYPE = 2'd0;
	localparam logic [1:0] CFG_SIDE_TYPE  = 2'd1;
	localparam logic [1:0] CFG_MIN_FRAME  = 2'd2;

	localparam logic [31:0] POINT_TYPE_RST = 32'd1020;
	localparam logic [31:0] SIDE_TYPE_RST  = 32'd1021;
	localparam logic [15:0] MIN_FRAME_RST  = 16'd44;

	localparam int unsigned REC_HDR_BYTES = 8;
	localparam logic [12:0] POINTS_MAX    = 13'd8191;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] point_index;
		logic [31:0] x_bits;
		logic [31:0] y_bits;
		logic [31:0] z_bits;
		logic [31:0] velocity_bits;
		logic [15:0] snr_tenths;
		logic [15:0] noise_tenths;
		logic [1:0]  status;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/rtfp_channels.sv
// Valid/ready channel interfaces for the frame parser: byte input and result output.
// Depends on nothing but the handshake convention (accept on valid & ready).
`default_nettype none

interface rtfp_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_value;
	logic        first_byte;
	logic [15:0] frame_bytes;

	modport source (output valid, byte_value, first_byte, frame_bytes, input ready);
	modport sink   (input valid, byte_value, first_byte, frame_bytes, output ready);
endinterface

interface rtfp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [11:0] point_index;
	logic [31:0] x_bits;
	logic [31:0] y_bits;
	logic [31:0] z_bits;
	logic [31:0] velocity_bits;
	logic [15:0] snr_tenths;
	logic [15:0] noise_tenths;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, kind, point_index, x_bits, y_bits, z_bits, velocity_bits,
		snr_tenths, noise_tenths, status, last, input ready);
	modport sink   (input valid, kind, point_index, x_bits, y_bits, z_bits, velocity_bits,
		snr_tenths, noise_tenths, status, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/radar_tlv_frame_parser.sv
// radar_tlv_frame_parser: byte-serial TLV frame parser, top level.
// Uses rtfp_pkg and the interfaces in rtfp_channels.sv.
//
//   channel     dir  handshake       payload
//   byte_in     in   valid/ready     byte_value, first_byte, frame_bytes
//   result_out  out  valid/ready     kind, point_index, x/y/z/velocity_bits,
//                                    snr_tenths, noise_tenths, status, last
//   cfg         in   cfg_we          cfg_index, cfg_data
//
// One byte per cycle while ready. A byte is registered, then parsed in the
// next cycle; its results (zero, one or two) land in an 8-entry result queue.
// Results pass the input register, then the queue, to result_out.
// byte_in.ready drops while the queue holds more than 4 items, so a stalled
// sink backs up into the byte side without loss. Reset leaves the parser idle.
`default_nettype none

module radar_tlv_frame_parser #(
	parameter int unsigned MAX_FRAME_BYTES   = 65536,
	parameter int unsigned HEADER_SKIP_BYTES = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	rtfp_byte_if.sink         byte_in,
	rtfp_result_if.source     result_out,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	localparam logic [15:0] FLEN_CAP =
		(MAX_FRAME_BYTES > 65535) ? 16'hFFFF : 16'(MAX_FRAME_BYTES);
	localparam logic [15:0] HDR_FIRST     = 16'(HEADER_SKIP_BYTES);
	localparam logic [15:0] HDR_COUNT_END = 16'(HEADER_SKIP_BYTES + 3);
	localparam logic [15:0] HDR_LAST      = 16'(HEADER_SKIP_BYTES + 7);
	localparam logic [16:0] HDR_MIN_LEN   = 17'(HEADER_SKIP_BYTES + 16);
	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	// configuration
	logic [31:0] ptype_q, stype_q;
	logic [15:0] min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptype_q <= rtfp_pkg::POINT_TYPE_RST;
			stype_q <= rtfp_pkg::SIDE_TYPE_RST;
			min_q   <= rtfp_pkg::MIN_FRAME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtfp_pkg::CFG_POINT_TYPE: ptype_q <= cfg_data;
				rtfp_pkg::CFG_SIDE_TYPE:  stype_q <= cfg_data;
				rtfp_pkg::CFG_MIN_FRAME:  min_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic [15:0] fbytes_s1;
	logic        in_acc;

	assign in_acc = byte_in.valid && byte_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1   <= byte_in.byte_value;
			first_s1  <= byte_in.first_byte;
			fbytes_s1 <= byte_in.frame_bytes;
		end
	end

	// parser state
	rtfp_pkg::phase_t phase_q, phase_n;
	logic [15:0]  pos_q, pos_n;
	logic [15:0]  flen_q, flen_n;
	logic [31:0]  rleft_q, rleft_n;
	logic [31:0]  rtype_q, rtype_n;
	logic [15:0]  rlen_q, rlen_n;
	logic [15:0]  rbs_q, rbs_n;
	logic [127:0] aw_q, aw_n;
	logic [12:0]  pts_q, pts_n;
	logic [12:0]  sidx_q, sidx_n;

	logic        go, do_finish, data_v, end_v;
	logic [1:0]  end_st;
	logic [16:0] pos_p1;
	logic [31:0] len32;
	rtfp_pkg::result_t data_res, end_res;

	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		flen_n   = flen_q;
		rleft_n  = rleft_q;
		rtype_n  = rtype_q;
		rlen_n   = rlen_q;
		rbs_n    = rbs_q;
		aw_n     = aw_q;
		pts_n    = pts_q;
		sidx_n   = sidx_q;
		go        = 1'b0;
		do_finish = 1'b0;
		data_v    = 1'b0;
		end_v     = 1'b0;
		end_st    = rtfp_pkg::ST_OK;
		data_res  = '0;
		len32     = aw_q[63:32];

		if (valid_s1) begin
			if (first_s1) begin
				flen_n  = (fbytes_s1 > FLEN_CAP) ? FLEN_CAP : fbytes_s1;
				pos_n   = '0;
				rleft_n = '0;
				rtype_n = '0;
				rlen_n  = '0;
				rbs_n   = '0;
				aw_n    = '0;
				pts_n   = '0;
				sidx_n  = '0;
				if (flen_n < min_q) begin
					end_v  = 1'b1;
					end_st = rtfp_pkg::ST_SMALL;
				end else begin
					phase_n = rtfp_pkg::PH_HEADER;
					go      = 1'b1;
				end
			end else if (phase_q != rtfp_pkg::PH_IDLE) begin
				if (pos_q != 16'hFFFF) pos_n = pos_q + 16'd1;
				go = 1'b1;
			end
		end

		pos_p1 = {1'b0, pos_n} + 17'd1;

		if (go) begin
			unique case (phase_n)
				rtfp_pkg::PH_HEADER: begin
					if (pos_n >= HDR_FIRST && pos_n <= HDR_COUNT_END)
						rleft_n = rleft_n | (32'(byte_s1) << {2'(pos_n - HDR_FIRST), 3'b000});
					if (pos_n == HDR_COUNT_END) begin
						if (rleft_n == '0) begin
							end_v = 1'b1;
						end else if (HDR_MIN_LEN > {1'b0, flen_n}
							|| pos_p1 >= {1'b0, flen_n}) begin
							end_v  = 1'b1;
							end_st = rtfp_pkg::ST_HDR_CUT;
						end
					end else if (pos_n == HDR_LAST) begin
						phase_n = rtfp_pkg::PH_RHDR;
						rbs_n   = '0;
						aw_n    = '0;
					end else if (pos_p1 >= {1'b0, flen_n}) begin
						end_v  = 1'b1;
						end_st = rtfp_pkg::ST_HDR_CUT;
					end
				end
				rtfp_pkg::PH_RHDR: begin
					aw_n  = aw_n | (128'(byte_s1) << {1'b0, rbs_n[2:0], 3'b000});
					rbs_n = rbs_n + 16'd1;
					if (rbs_n >= 16'(REC_HDR_BYTES_W)) begin
						rtype_n = aw_n[31:0];
						len32   = aw_n[63:32];
						rlen_n  = len32[15:0];
						rbs_n   = '0;
						aw_n    = '0;
						if (({16'b0, pos_p1} + {1'b0, len32}) > {17'b0, flen_n}) begin
							end_v  = 1'b1;
							end_st = rtfp_pkg::ST_OVERRUN;
						end else begin
							sidx_n = '0;
							if (len32 == '0) do_finish = 1'b1;
							else phase_n = rtfp_pkg::PH_VALUE;
						end
					end
				end
				rtfp_pkg::PH_VALUE: begin
					aw_n  = aw_n | (128'(byte_s1) << {rbs_n[3:0], 3'b000});
					rbs_n = rbs_n + 16'd1;
					if (rtype_q == ptype_q) begin
						if (rbs_n[3:0] == 4'd0) begin
							data_v                 = 1'b1;
							data_res.kind          = rtfp_pkg::KIND_POINT;
							data_res.point_index   = pts_n[11:0];
							data_res.x_bits        = aw_n[31:0];
							data_res.y_bits        = aw_n[63:32];
							data_res.z_bits        = aw_n[95:64];
							data_res.velocity_bits = aw_n[127:96];
							if (pts_n < rtfp_pkg::POINTS_MAX) pts_n = pts_n + 13'd1;
							aw_n = '0;
						end
					end else if (rtype_q == stype_q) begin
						if (rbs_n[1:0] == 2'd0) begin
							if (sidx_n < pts_n) begin
								data_v                = 1'b1;
								data_res.kind         = rtfp_pkg::KIND_SIDE;
								data_res.point_index  = sidx_n[11:0];
								data_res.snr_tenths   = aw_n[15:0];
								data_res.noise_tenths = aw_n[31:16];
								sidx_n = sidx_n + 13'd1;
							end
							aw_n = '0;
						end
					end
					if (rbs_n >= rlen_n) do_finish = 1'b1;
				end
				default: ;
			endcase
		end

		if (do_finish) begin
			rleft_n = rleft_n - 32'd1;
			rbs_n   = '0;
			aw_n    = '0;
			if (rleft_n == '0) begin
				end_v = 1'b1;
			end else if ((pos_p1 + 17'd8) > {1'b0, flen_n}) begin
				end_v  = 1'b1;
				end_st = rtfp_pkg::ST_HDR_CUT;
			end else begin
				phase_n = rtfp_pkg::PH_RHDR;
			end
		end

		if (end_v) phase_n = rtfp_pkg::PH_IDLE;

		end_res        = '0;
		end_res.kind   = rtfp_pkg::KIND_END;
		end_res.status = end_st;
		end_res.last   = 1'b1;
	end

	localparam int unsigned REC_HDR_BYTES_W = rtfp_pkg::REC_HDR_BYTES;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rtfp_pkg::PH_IDLE;
			pos_q   <= '0;
			flen_q  <= '0;
			rleft_q <= '0;
			rtype_q <= '0;
			rlen_q  <= '0;
			rbs_q   <= '0;
			pts_q   <= '0;
			sidx_q  <= '0;
		end else begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			flen_q  <= flen_n;
			rleft_q <= rleft_n;
			rtype_q <= rtype_n;
			rlen_q  <= rlen_n;
			rbs_q   <= rbs_n;
			pts_q   <= pts_n;
			sidx_q  <= sidx_n;
		end
	end

	always_ff @(posedge clk) begin
		aw_q <= aw_n;
	end

	// result queue; a byte writes up to two items, the second is always frame end
	rtfp_pkg::result_t qmem [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	logic           wr0, wr1, pop;
	rtfp_pkg::result_t res0, head;

	assign wr0  = data_v || end_v;
	assign wr1  = data_v && end_v;
	assign res0 = data_v ? data_res : end_res;
	assign pop  = result_out.valid && result_out.ready;

	always_ff @(posedge clk) begin
		if (wr0) qmem[wp_q] <= res0;
		if (wr1) qmem[wp_q + QAW'(1)] <= end_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QAW'(wr0) + QAW'(wr1);
			rp_q  <= rp_q + QAW'(pop);
			cnt_q <= cnt_q + (QAW+1)'(wr0) + (QAW+1)'(wr1) - (QAW+1)'(pop);
		end
	end

	// room for the item in the input register and the one taken now
	assign byte_in.ready = (cnt_q <= (QAW+1)'(QDEPTH - 4));

	assign head                     = qmem[rp_q];
	assign result_out.valid         = (cnt_q != '0);
	assign result_out.kind          = head.kind;
	assign result_out.point_index   = head.point_index;
	assign result_out.x_bits        = head.x_bits;
	assign result_out.y_bits        = head.y_bits;
	assign result_out.z_bits        = head.z_bits;
	assign result_out.velocity_bits = head.velocity_bits;
	assign result_out.snr_tenths    = head.snr_tenths;
	assign result_out.noise_tenths  = head.noise_tenths;
	assign result_out.status        = head.status;
	assign result_out.last          = head.last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAW+1)'(QDEPTH))
		else $error("result queue overflow");

	a_end_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && end_v) |=> (phase_q == rtfp_pkg::PH_IDLE))
		else $error("parser not idle after frame end");

	a_side_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sidx_q <= pts_q)
		else $error("side index passed point count");

	a_pair_has_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && result_out.last) |-> (result_out.kind == rtfp_pkg::KIND_END))
		else $error("last set on a non-end item");

endmodule

`default_nettype wire
